/* hw/rtl/ufhf_pkg.sv */
`default_nettype none
package ufhf_pkg;

   // Build defaults
   localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Frame layout
   localparam int unsigned ETH_HDR_BYTES    = 14;
   localparam int unsigned MIN_IP_HDR_BYTES = 20;
   localparam int unsigned UDP_HDR_BYTES    = 8;
   localparam int unsigned UDP_LATCH_BYTES  = 6;
   localparam int unsigned MIN_FRAME_BYTES  = ETH_HDR_BYTES + MIN_IP_HDR_BYTES + UDP_HDR_BYTES;
   localparam int unsigned MIN_IHL          = MIN_IP_HDR_BYTES / 4;

   localparam int unsigned OFS_ETHER_HI  = 12;
   localparam int unsigned OFS_ETHER_LO  = 13;
   localparam int unsigned OFS_VER_IHL   = 14;
   localparam int unsigned OFS_PROTOCOL  = 23;
   localparam int unsigned OFS_SRC_FIRST = 26;
   localparam int unsigned OFS_SRC_LAST  = 29;
   localparam int unsigned OFS_DST_FIRST = 30;
   localparam int unsigned OFS_DST_LAST  = 33;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [3:0]  IP_VERSION_4   = 4'd4;
   localparam logic [3:0]  IHL_MASK       = 4'hF;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFO_PORT         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR_ADDR_CHECK = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR_ADDR       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOST_ADDR_CHECK   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOST_ADDR         = 3'd4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      DROP_NONE           = 3'd0,
      DROP_SHORT          = 3'd1,
      DROP_ETHERTYPE      = 3'd2,
      DROP_VERSION_IHL    = 3'd3,
      DROP_TRUNCATED      = 3'd4,
      DROP_NOT_UDP        = 3'd5,
      DROP_UDP_LEN        = 3'd6,
      DROP_PAYLOAD_FILTER = 3'd7
   } drop_reason_type;

   typedef struct packed {
      logic [15:0] ether_kind;
      logic [7:0]  version_ihl;
      logic [7:0]  ip_protocol;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] udp_len;
   } frame_hdr_type;

   typedef struct packed {
      logic [15:0] info_port;
      logic        sensor_addr_check;
      logic [31:0] sensor_addr;
      logic        host_addr_check;
      logic [31:0] host_addr;
   } filter_cfg_type;

endpackage
`default_nettype wire

/* hw/rtl/ufhf_front.sv */
`default_nettype none
module ufhf_front #(
   parameter int unsigned COUNT_WIDTH = ufhf_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_frame_byte,
   input  logic                    req_frame_end,
   input  logic                    queue_full,
   output logic                    push_valid,
   output logic [COUNT_WIDTH-1:0]  push_caplen,
   output ufhf_pkg::frame_hdr_type push_hdr
);
   import ufhf_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in, count_next;
   frame_hdr_type          hdr_ff, hdr_in, hdr_upd;
   logic                   accept;
   logic [3:0]             ihl;
   logic [COUNT_WIDTH-1:0] pos, udp_start;
   logic                   in_udp;
   logic [2:0]             udp_k;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign pos       = byte_count_ff;
   assign ihl       = hdr_ff.version_ihl[3:0] & IHL_MASK;
   assign udp_start = COUNT_WIDTH'(ETH_HDR_BYTES) + COUNT_WIDTH'({ihl, 2'b00});
   assign in_udp    = (ihl >= 4'(MIN_IHL)) && (pos >= udp_start)
                      && (pos < udp_start + COUNT_WIDTH'(UDP_LATCH_BYTES));
   assign udp_k     = 3'(pos - udp_start);

   // Shift the current byte into whichever header field sits at this offset
   always_comb begin
      hdr_upd = hdr_ff;
      if (pos == COUNT_WIDTH'(OFS_ETHER_HI) || pos == COUNT_WIDTH'(OFS_ETHER_LO)) begin
         hdr_upd.ether_kind = {hdr_ff.ether_kind[7:0], req_frame_byte};
      end else if (pos == COUNT_WIDTH'(OFS_VER_IHL)) begin
         hdr_upd.version_ihl = req_frame_byte;
      end else if (pos == COUNT_WIDTH'(OFS_PROTOCOL)) begin
         hdr_upd.ip_protocol = req_frame_byte;
      end else if (pos >= COUNT_WIDTH'(OFS_SRC_FIRST) && pos <= COUNT_WIDTH'(OFS_SRC_LAST)) begin
         hdr_upd.source_addr = {hdr_ff.source_addr[23:0], req_frame_byte};
      end else if (pos >= COUNT_WIDTH'(OFS_DST_FIRST) && pos <= COUNT_WIDTH'(OFS_DST_LAST)) begin
         hdr_upd.dest_addr = {hdr_ff.dest_addr[23:0], req_frame_byte};
      end
      if (in_udp) begin
         if (udp_k < 3'd2) begin
            hdr_upd.source_port = {hdr_ff.source_port[7:0], req_frame_byte};
         end else if (udp_k < 3'd4) begin
            hdr_upd.dest_port = {hdr_ff.dest_port[7:0], req_frame_byte};
         end else begin
            hdr_upd.udp_len = {hdr_ff.udp_len[7:0], req_frame_byte};
         end
      end
   end

   assign count_next    = (pos == COUNT_MAX) ? pos : pos + 1'b1;
   assign byte_count_in = req_frame_end ? '0 : count_next;
   assign hdr_in        = req_frame_end ? '0 : hdr_upd;

   assign push_valid  = accept && req_frame_end;
   assign push_caplen = count_next;
   assign push_hdr    = hdr_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         hdr_ff        <= '0;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         hdr_ff        <= hdr_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/ufhf_queue.sv */
`default_nettype none
module ufhf_queue #(
   parameter int unsigned COUNT_WIDTH = ufhf_pkg::COUNT_WIDTH_DEFAULT,
   parameter int unsigned DEPTH       = ufhf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  logic [COUNT_WIDTH-1:0]  push_caplen,
   input  ufhf_pkg::frame_hdr_type push_hdr,
   output logic                    full,
   input  logic                    pop,
   output logic                    pop_valid,
   output logic [COUNT_WIDTH-1:0]  pop_caplen,
   output ufhf_pkg::frame_hdr_type pop_hdr
);
   import ufhf_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [COUNT_WIDTH-1:0] caplen_mem [DEPTH];
   frame_hdr_type          hdr_mem    [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full       = (fill_ff == CNT_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && pop_valid;
   assign pop_caplen = caplen_mem[rd_ptr_ff];
   assign pop_hdr    = hdr_mem[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         caplen_mem[wr_ptr_ff] <= push_caplen;
         hdr_mem[wr_ptr_ff]    <= push_hdr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         fill_ff <= fill_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/ufhf_back.sv */
`default_nettype none
module ufhf_back #(
   parameter int unsigned COUNT_WIDTH = ufhf_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     entry_valid,
   input  logic [COUNT_WIDTH-1:0]   entry_caplen,
   input  ufhf_pkg::frame_hdr_type  entry_hdr,
   output logic                     entry_pop,
   input  ufhf_pkg::filter_cfg_type cfg,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_accepted,
   output logic [2:0]               rsp_drop_reason,
   output logic                     rsp_filter_miss,
   output logic [15:0]              rsp_payload_length,
   output logic [6:0]               rsp_payload_offset
);
   import ufhf_pkg::*;

   localparam int unsigned CMP_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

   logic [CMP_W-1:0] cap_ext, udp_end;
   logic [3:0]       version, ihl;
   logic [5:0]       ip_hdr;
   logic [6:0]       hdr_end;
   logic             port_ok, src_ok, dst_ok, take;

   drop_reason_type reason;
   logic            miss;
   logic [15:0]     plen;
   logic [6:0]      poff;

   logic            rsp_valid_ff;
   drop_reason_type reason_ff;
   logic            miss_ff;
   logic [15:0]     plen_ff;
   logic [6:0]      poff_ff;

   assign cap_ext = CMP_W'(entry_caplen);
   assign version = entry_hdr.version_ihl[7:4];
   assign ihl     = entry_hdr.version_ihl[3:0] & IHL_MASK;
   assign ip_hdr  = {ihl, 2'b00};
   assign hdr_end = 7'(ETH_HDR_BYTES) + 7'(ip_hdr) + 7'(UDP_HDR_BYTES);
   assign udp_end = CMP_W'(ETH_HDR_BYTES) + CMP_W'(ip_hdr) + CMP_W'(entry_hdr.udp_len);
   assign port_ok = (entry_hdr.source_port == cfg.info_port)
                    || (entry_hdr.dest_port == cfg.info_port);
   assign src_ok  = !cfg.sensor_addr_check || (entry_hdr.source_addr == cfg.sensor_addr);
   assign dst_ok  = !cfg.host_addr_check || (entry_hdr.dest_addr == cfg.host_addr);

   // First failing check wins
   always_comb begin
      reason = DROP_NONE;
      miss   = 1'b0;
      plen   = '0;
      poff   = '0;
      if (cap_ext < CMP_W'(MIN_FRAME_BYTES)) begin
         reason = DROP_SHORT;
      end else if (entry_hdr.ether_kind != ETHERTYPE_IPV4) begin
         reason = DROP_ETHERTYPE;
      end else if (version != IP_VERSION_4 || ihl < 4'(MIN_IHL)) begin
         reason = DROP_VERSION_IHL;
      end else begin
         poff = hdr_end;
         if (cap_ext < CMP_W'(hdr_end)) begin
            reason = DROP_TRUNCATED;
         end else if (entry_hdr.ip_protocol != PROTO_UDP) begin
            reason = DROP_NOT_UDP;
         end else if (entry_hdr.udp_len < 16'(UDP_HDR_BYTES)) begin
            reason = DROP_UDP_LEN;
         end else if (cap_ext < udp_end) begin
            reason = DROP_PAYLOAD_FILTER;
         end else if (port_ok && src_ok && dst_ok) begin
            plen = entry_hdr.udp_len - 16'(UDP_HDR_BYTES);
         end else begin
            reason = DROP_PAYLOAD_FILTER;
            miss   = 1'b1;
         end
      end
   end

   assign take      = entry_valid && (!rsp_valid_ff || rsp_ready);
   assign entry_pop = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         reason_ff <= reason;
         miss_ff   <= miss;
         plen_ff   <= plen;
         poff_ff   <= poff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = (reason_ff == DROP_NONE);
   assign rsp_drop_reason    = reason_ff;
   assign rsp_filter_miss    = miss_ff;
   assign rsp_payload_length = plen_ff;
   assign rsp_payload_offset = poff_ff;

endmodule
`default_nettype wire

/* hw/rtl/udp_frame_header_filter.sv */
`default_nettype none
// Ethernet/IPv4/UDP header filter. Feed a captured frame one byte per request on req_*,
// with req_frame_end set on its last byte; each frame gives exactly one response on
// rsp_*: accepted, the first drop reason (short capture, ethertype, version/IHL,
// truncated headers, not UDP, UDP length below 8, payload beyond the capture or a filter
// miss), and the payload length and offset. The parser takes one byte every clock cycle,
// also across frame boundaries, while the QUEUE_DEPTH-entry queue of parsed headers has
// room; once the queue is full, req_ready drops and every byte waits until the back end
// takes a header. A frame's header enters the queue when its last byte is accepted; the
// back end registers its response, which then shows on rsp_valid. Capture lengths count
// to 2^COUNT_WIDTH-1 and then saturate. Write the filter registers through csr_* only
// while no frame is in flight; unknown register indexes are ignored.
module udp_frame_header_filter #(
   parameter int unsigned COUNT_WIDTH = ufhf_pkg::COUNT_WIDTH_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = ufhf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // byte requests
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_frame_byte,
   input  logic                             req_frame_end,
   // per-frame responses
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_accepted,
   output logic [2:0]                       rsp_drop_reason,
   output logic                             rsp_filter_miss,
   output logic [15:0]                      rsp_payload_length,
   output logic [6:0]                       rsp_payload_offset,
   // filter registers
   input  logic                             csr_we,
   input  logic [ufhf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ufhf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ufhf_pkg::*;

   filter_cfg_type cfg_ff, cfg_in;

   logic                   queue_full, push_valid, entry_valid, entry_pop;
   logic [COUNT_WIDTH-1:0] push_caplen, entry_caplen;
   frame_hdr_type          push_hdr, entry_hdr;

   // Decode a register write; leave everything else as it stands
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_INFO_PORT:         cfg_in.info_port         = csr_wdata[15:0];
            CSR_SENSOR_ADDR_CHECK: cfg_in.sensor_addr_check = csr_wdata[0];
            CSR_SENSOR_ADDR:       cfg_in.sensor_addr       = csr_wdata[31:0];
            CSR_HOST_ADDR_CHECK:   cfg_in.host_addr_check   = csr_wdata[0];
            CSR_HOST_ADDR:         cfg_in.host_addr         = csr_wdata[31:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: count bytes and latch header fields at line rate while the queue has room
   ufhf_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_frame_byte (req_frame_byte),
      .req_frame_end  (req_frame_end),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_caplen    (push_caplen),
      .push_hdr       (push_hdr)
   );

   // Hold finished headers so the parser waits on the response side only once the queue is full
   ufhf_queue #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .DEPTH      (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_caplen (push_caplen),
      .push_hdr    (push_hdr),
      .full        (queue_full),
      .pop         (entry_pop),
      .pop_valid   (entry_valid),
      .pop_caplen  (entry_caplen),
      .pop_hdr     (entry_hdr)
   );

   // Back: run the checks and filters, register the response
   ufhf_back #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .entry_valid        (entry_valid),
      .entry_caplen       (entry_caplen),
      .entry_hdr          (entry_hdr),
      .entry_pop          (entry_pop),
      .cfg                (cfg_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_drop_reason    (rsp_drop_reason),
      .rsp_filter_miss    (rsp_filter_miss),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_offset (rsp_payload_offset)
   );

endmodule
`default_nettype wire

/* bench/udp_frame_header_filter_tb.sv */
module udp_frame_header_filter_tb;
   import ufhf_pkg::*;

   // One frame verdict as it leaves the block on the response channel
   typedef struct packed {
      logic            accepted;
      drop_reason_type reason;
      logic            miss;
      logic [15:0]     plen;
      logic [6:0]      poff;
   } frame_verdict_type;

   // Directed frame: header fields, capture length and, where obvious, the verdict
   typedef struct packed {
      frame_hdr_type     hdr;
      logic [15:0]       caplen;
      logic              fixed_exp;
      frame_verdict_type verdict;
   } frame_row_type;

   // What the sender tells the checker about each frame before driving it
   typedef struct packed {
      logic              fixed_exp;
      frame_verdict_type verdict;
   } frame_note_type;

   localparam logic [15:0] OTHER_ETHERTYPE = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP       = 8'd6;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_frame_byte;
   logic                   req_frame_end;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_accepted;
   logic [2:0]             rsp_drop_reason;
   logic                   rsp_filter_miss;
   logic [15:0]            rsp_payload_length;
   logic [6:0]             rsp_payload_offset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Predictor state: position in the frame, latched header and the filter registers
   logic [15:0]    byte_pos;
   frame_hdr_type  seen;
   filter_cfg_type filters;

   frame_verdict_type verdict_q[$];
   frame_note_type    frame_note_q[$];
   logic [7:0]        frame_buf[$];
   frame_row_type     dir_table[$];
   int unsigned       mismatch_count;
   int unsigned       burst_left;
   int unsigned       stall_left;
   int unsigned       stall_mode;
   int unsigned       stall_tick;

   udp_frame_header_filter u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_frame_byte     (req_frame_byte),
      .req_frame_end      (req_frame_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_drop_reason    (rsp_drop_reason),
      .rsp_filter_miss    (rsp_filter_miss),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_offset (rsp_payload_offset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // Advance the predictor by one accepted byte; return 1 with the verdict on a frame end
   function automatic bit track_frame_byte(input logic [7:0] b, input logic last,
                                           output frame_verdict_type v);
      int unsigned pos, ihl, udp_at, caplen, ip_hdr, k;
      bit          port_ok, src_ok, dst_ok;
      v = '0;
      pos = 32'(byte_pos);
      ihl = 32'(seen.version_ihl[3:0]);
      udp_at = ETH_HDR_BYTES + 4 * ihl;

      // latch the Ethernet and IPv4 fields at their fixed offsets
      if (pos == OFS_ETHER_HI || pos == OFS_ETHER_LO)
         seen.ether_kind = {seen.ether_kind[7:0], b};
      else if (pos == OFS_VER_IHL)
         seen.version_ihl = b;
      else if (pos == OFS_PROTOCOL)
         seen.ip_protocol = b;
      else if (pos >= OFS_SRC_FIRST && pos <= OFS_SRC_LAST)
         seen.source_addr = {seen.source_addr[23:0], b};
      else if (pos >= OFS_DST_FIRST && pos <= OFS_DST_LAST)
         seen.dest_addr = {seen.dest_addr[23:0], b};

      // the UDP header only moves once a sane IHL has been seen
      if (ihl >= MIN_IHL && pos >= udp_at && pos < udp_at + UDP_LATCH_BYTES) begin
         k = pos - udp_at;
         if (k < 2)
            seen.source_port = {seen.source_port[7:0], b};
         else if (k < 4)
            seen.dest_port = {seen.dest_port[7:0], b};
         else
            seen.udp_len = {seen.udp_len[7:0], b};
      end

      // the capture length sticks at its ceiling
      if (byte_pos != 16'hFFFF)
         byte_pos = byte_pos + 16'd1;
      if (!last)
         return 1'b0;

      caplen = 32'(byte_pos);
      ihl = 32'(seen.version_ihl[3:0]);
      ip_hdr = 4 * ihl;
      v.reason = DROP_NONE;
      if (caplen < MIN_FRAME_BYTES)
         v.reason = DROP_SHORT;
      else if (seen.ether_kind != ETHERTYPE_IPV4)
         v.reason = DROP_ETHERTYPE;
      else if (seen.version_ihl[7:4] != IP_VERSION_4 || ip_hdr < MIN_IP_HDR_BYTES)
         v.reason = DROP_VERSION_IHL;
      else begin
         v.poff = 7'(ETH_HDR_BYTES + ip_hdr + UDP_HDR_BYTES);
         if (caplen < ETH_HDR_BYTES + ip_hdr + UDP_HDR_BYTES)
            v.reason = DROP_TRUNCATED;
         else if (seen.ip_protocol != PROTO_UDP)
            v.reason = DROP_NOT_UDP;
         else if (32'(seen.udp_len) < UDP_HDR_BYTES)
            v.reason = DROP_UDP_LEN;
         else if (caplen - ETH_HDR_BYTES - ip_hdr < 32'(seen.udp_len))
            v.reason = DROP_PAYLOAD_FILTER;
         else begin
            port_ok = seen.source_port == filters.info_port ||
                      seen.dest_port == filters.info_port;
            src_ok = !filters.sensor_addr_check || seen.source_addr == filters.sensor_addr;
            dst_ok = !filters.host_addr_check || seen.dest_addr == filters.host_addr;
            if (port_ok && src_ok && dst_ok)
               v.plen = seen.udp_len - 16'(UDP_HDR_BYTES);
            else begin
               v.reason = DROP_PAYLOAD_FILTER;
               v.miss = 1'b1;
            end
         end
      end
      v.accepted = v.reason == DROP_NONE;

      // frame done: clear everything but the registers
      byte_pos = '0;
      seen = '0;
      return 1'b1;
   endfunction

   function automatic frame_row_type dir_row(logic [15:0] ether, logic [7:0] ver_ihl,
                                             logic [7:0] proto, logic [15:0] sport,
                                             logic [15:0] dport, logic [15:0] ulen,
                                             int unsigned caplen, logic fixed_exp,
                                             drop_reason_type reason, logic miss,
                                             logic [15:0] plen, logic [6:0] poff);
      frame_row_type r;
      r.hdr.ether_kind = ether;
      r.hdr.version_ihl = ver_ihl;
      r.hdr.ip_protocol = proto;
      r.hdr.source_addr = $urandom;
      r.hdr.dest_addr = $urandom;
      r.hdr.source_port = sport;
      r.hdr.dest_port = dport;
      r.hdr.udp_len = ulen;
      r.caplen = 16'(caplen);
      r.fixed_exp = fixed_exp;
      r.verdict.accepted = reason == DROP_NONE;
      r.verdict.reason = reason;
      r.verdict.miss = miss;
      r.verdict.plen = plen;
      r.verdict.poff = poff;
      return r;
   endfunction

   // Lay the header out over random filler; bytes past the capture are cut off
   function automatic void assemble_frame(frame_hdr_type h, int unsigned caplen);
      int unsigned ihl, udp_at, i;
      logic [47:0] udp_hdr;
      logic [7:0]  b;
      frame_buf.delete();
      ihl = 32'(h.version_ihl[3:0]);
      udp_at = (ihl >= MIN_IHL) ? ETH_HDR_BYTES + 4 * ihl : MIN_FRAME_BYTES - UDP_HDR_BYTES;
      udp_hdr = {h.source_port, h.dest_port, h.udp_len};
      for (i = 0; i < caplen; i++) begin
         b = 8'($urandom);
         if (i == OFS_ETHER_HI)
            b = h.ether_kind[15:8];
         else if (i == OFS_ETHER_LO)
            b = h.ether_kind[7:0];
         else if (i == OFS_VER_IHL)
            b = h.version_ihl;
         else if (i == OFS_PROTOCOL)
            b = h.ip_protocol;
         else if (i >= OFS_SRC_FIRST && i <= OFS_SRC_LAST)
            b = h.source_addr[8 * (OFS_SRC_LAST - i) +: 8];
         else if (i >= OFS_DST_FIRST && i <= OFS_DST_LAST)
            b = h.dest_addr[8 * (OFS_DST_LAST - i) +: 8];
         else if (i >= udp_at && i < udp_at + UDP_LATCH_BYTES)
            b = udp_hdr[8 * (UDP_LATCH_BYTES - 1 - (i - udp_at)) +: 8];
         frame_buf.push_back(b);
      end
   endfunction

   // Mostly well-formed frames aimed at the current filters, then broken ones and noise
   function automatic void draw_frame(output frame_hdr_type h, output int unsigned caplen);
      int unsigned sel, ihl, ver;
      sel = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 2) == 0) ? $urandom_range(MIN_IHL + 1, 15) : MIN_IHL;
      h.ether_kind = ETHERTYPE_IPV4;
      h.version_ihl = {IP_VERSION_4, 4'(ihl)};
      h.ip_protocol = PROTO_UDP;
      h.source_addr = ($urandom_range(0, 4) != 0) ? filters.sensor_addr : $urandom;
      h.dest_addr = ($urandom_range(0, 4) != 0) ? filters.host_addr : $urandom;
      h.source_port = 16'($urandom);
      h.dest_port = 16'($urandom);
      if ($urandom_range(0, 6) != 0) begin
         if ($urandom_range(0, 1) == 1)
            h.source_port = filters.info_port;
         else
            h.dest_port = filters.info_port;
      end
      h.udp_len = 16'(UDP_HDR_BYTES + $urandom_range(0, 24));
      caplen = ETH_HDR_BYTES + 4 * ihl + 32'(h.udp_len);
      if ($urandom_range(0, 2) == 0)
         caplen += $urandom_range(1, 6);

      if (sel >= 85) begin
         // noise: nothing lines up unless by luck
         h.ether_kind = ($urandom_range(0, 2) == 0) ? ETHERTYPE_IPV4 : 16'($urandom);
         h.version_ihl = ($urandom_range(0, 2) == 0) ? {IP_VERSION_4, 4'($urandom)}
                                                      : 8'($urandom);
         h.ip_protocol = ($urandom_range(0, 2) == 0) ? PROTO_UDP : 8'($urandom);
         h.source_addr = $urandom;
         h.dest_addr = $urandom;
         h.udp_len = 16'($urandom);
         caplen = $urandom_range(1, 90);
      end else if (sel >= 65) begin
         // break one thing in an otherwise good frame
         case ($urandom_range(0, 6))
            0: h.ether_kind = 16'($urandom);
            1: begin
               ver = $urandom_range(0, 14);
               if (ver >= IP_VERSION_4)
                  ver++;
               h.version_ihl[7:4] = 4'(ver);
            end
            2: h.version_ihl[3:0] = 4'($urandom_range(0, MIN_IHL - 1));
            3: h.ip_protocol = 8'($urandom);
            4: caplen = $urandom_range(1, ETH_HDR_BYTES + 4 * ihl + UDP_HDR_BYTES - 1);
            5: h.udp_len = 16'($urandom_range(0, UDP_HDR_BYTES - 1));
            default: h.udp_len = 16'(caplen - ETH_HDR_BYTES - 4 * ihl +
                                     $urandom_range(1, 40000));
         endcase
      end
   endfunction

   // Offer one byte; bursts of random length with random gaps in between
   task automatic offer_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         if ($urandom_range(0, 3) != 0)
            gap = $urandom_range(1, 6);
      end
      burst_left--;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_frame_byte <= b;
      req_frame_end <= last;
      // hold until the request is taken
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic send_frame(input logic fixed_exp, input frame_verdict_type v);
      frame_note_type note;
      int unsigned    i;
      note.fixed_exp = fixed_exp;
      note.verdict = v;
      frame_note_q.push_back(note);
      for (i = 0; i < frame_buf.size(); i++)
         offer_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   // Drop valid and wait for every verdict, then let the pipeline drain
   task automatic drain_frames();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdict_q.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Write all five filter registers back to back, plus one write to a spare index
   task automatic program_filters(input filter_cfg_type c);
      logic [CSR_INDEX_W-1:0] spare_index;
      spare_index = CSR_INDEX_W'($urandom_range(CSR_HOST_ADDR + 1, (1 << CSR_INDEX_W) - 1));
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_INFO_PORT;
      csr_wdata <= {16'($urandom), c.info_port};
      @(negedge clock);
      csr_index <= CSR_SENSOR_ADDR_CHECK;
      csr_wdata <= {31'($urandom), c.sensor_addr_check};
      @(negedge clock);
      csr_index <= CSR_SENSOR_ADDR;
      csr_wdata <= c.sensor_addr;
      @(negedge clock);
      csr_index <= CSR_HOST_ADDR_CHECK;
      csr_wdata <= {31'($urandom), c.host_addr_check};
      @(negedge clock);
      csr_index <= CSR_HOST_ADDR;
      csr_wdata <= c.host_addr;
      @(negedge clock);
      csr_index <= spare_index;
      csr_wdata <= $urandom;
      @(negedge clock);
      csr_we <= 1'b0;
      filters = c;
   endtask

   // Receiver: stretches of always-ready, coin-flip, mostly-stalled and a fixed rhythm
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 120);
      end else
         stall_left--;
      stall_tick++;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= $urandom_range(0, 7) == 0;
         default: rsp_ready <= stall_tick[1:0] != 2'd0;
      endcase
   end

   // Check each verdict against the oldest expectation, then predict from the request
   always @(posedge clock) begin
      frame_verdict_type got, want, predicted;
      frame_note_type    note;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            got.accepted = rsp_accepted;
            got.reason = drop_reason_type'(rsp_drop_reason);
            got.miss = rsp_filter_miss;
            got.plen = rsp_payload_length;
            got.poff = rsp_payload_offset;
            if (verdict_q.size() == 0) begin
               $display({"%0t: unexpected verdict: expected none, got acc=%0d reason=%0d ",
                         "miss=%0d len=%0d off=%0d"},
                        $time, got.accepted, got.reason, got.miss, got.plen, got.poff);
               mismatch_count++;
            end else begin
               want = verdict_q.pop_front();
               if (got !== want) begin
                  $display({"%0t: verdict mismatch: expected acc=%0d reason=%0d miss=%0d ",
                            "len=%0d off=%0d, got acc=%0d reason=%0d miss=%0d len=%0d ",
                            "off=%0d"},
                           $time, want.accepted, want.reason, want.miss, want.plen,
                           want.poff, got.accepted, got.reason, got.miss, got.plen,
                           got.poff);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (track_frame_byte(req_frame_byte, req_frame_end, predicted)) begin
               note = frame_note_q.pop_front();
               verdict_q.push_back(note.fixed_exp ? note.verdict : predicted);
            end
         end
      end
   end

   initial begin
      frame_hdr_type  h;
      filter_cfg_type c;
      int unsigned    caplen, bytes, ph, r;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_frame_byte = '0;
      req_frame_end = 1'b0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      byte_pos = '0;
      seen = '0;
      filters = '0;
      mismatch_count = 0;
      burst_left = 0;
      stall_left = 0;
      stall_mode = 0;
      stall_tick = 0;

      // Directed frames under the reset filters: port 0, address checks off.
      // Verdicts are typed in where they are plain; the rest go to the predictor.
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0, 16'h0, 16'd8, 1,
                                  1'b1, DROP_SHORT, 1'b0, 16'd0, 7'd0));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0, 16'h0, 16'd8, 41,
                                  1'b1, DROP_SHORT, 1'b0, 16'd0, 7'd0));
      dir_table.push_back(dir_row(OTHER_ETHERTYPE, 8'h45, PROTO_UDP, 16'h0, 16'h0, 16'd8, 42,
                                  1'b1, DROP_ETHERTYPE, 1'b0, 16'd0, 7'd0));
      dir_table.push_back(dir_row(16'h0008, 8'h45, PROTO_UDP, 16'h0, 16'h0, 16'd8, 42,
                                  1'b1, DROP_ETHERTYPE, 1'b0, 16'd0, 7'd0));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h65, PROTO_UDP, 16'h0, 16'h0, 16'd8, 42,
                                  1'b1, DROP_VERSION_IHL, 1'b0, 16'd0, 7'd0));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h44, PROTO_UDP, 16'h0, 16'h0, 16'd8, 42,
                                  1'b1, DROP_VERSION_IHL, 1'b0, 16'd0, 7'd0));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h40, PROTO_UDP, 16'h0, 16'h0, 16'd8, 42,
                                  1'b1, DROP_VERSION_IHL, 1'b0, 16'd0, 7'd0));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'hF5, PROTO_UDP, 16'h0, 16'h0, 16'd8, 42,
                                  1'b1, DROP_VERSION_IHL, 1'b0, 16'd0, 7'd0));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h46, PROTO_UDP, 16'h0, 16'h0, 16'd8, 45,
                                  1'b1, DROP_TRUNCATED, 1'b0, 16'd0, 7'd46));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h4F, PROTO_UDP, 16'h0, 16'h0, 16'd8, 81,
                                  1'b1, DROP_TRUNCATED, 1'b0, 16'd0, 7'd82));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 16'h0, 16'h0, 16'd8, 42,
                                  1'b1, DROP_NOT_UDP, 1'b0, 16'd0, 7'd42));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0, 16'h0, 16'd0, 42,
                                  1'b1, DROP_UDP_LEN, 1'b0, 16'd0, 7'd42));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0, 16'h0, 16'd7, 42,
                                  1'b1, DROP_UDP_LEN, 1'b0, 16'd0, 7'd42));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0, 16'h0, 16'd9, 42,
                                  1'b1, DROP_PAYLOAD_FILTER, 1'b0, 16'd0, 7'd42));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0, 16'h0, 16'hFFFF,
                                  42, 1'b1, DROP_PAYLOAD_FILTER, 1'b0, 16'd0, 7'd42));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h04D2, 16'h04D2, 16'd8,
                                  42, 1'b1, DROP_PAYLOAD_FILTER, 1'b1, 16'd0, 7'd42));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0, 16'h04D2, 16'd8, 42,
                                  1'b1, DROP_NONE, 1'b0, 16'd0, 7'd42));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'hFFFF, 16'h0, 16'd20,
                                  60, 1'b1, DROP_NONE, 1'b0, 16'd12, 7'd42));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h4F, PROTO_UDP, 16'h0, 16'hFFFF, 16'd8, 82,
                                  1'b1, DROP_NONE, 1'b0, 16'd0, 7'd82));
      dir_table.push_back(dir_row(ETHERTYPE_IPV4, 8'h46, PROTO_UDP, 16'h0, 16'h0, 16'd12, 56,
                                  1'b0, DROP_NONE, 1'b0, 16'd0, 7'd0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < dir_table.size(); r++) begin
         assemble_frame(dir_table[r].hdr, 32'(dir_table[r].caplen));
         send_frame(dir_table[r].fixed_exp, dir_table[r].verdict);
      end

      // Random phases, each with its own filter setting; extremes come in phases 1 and 4
      for (ph = 1; ph <= 5; ph++) begin
         drain_frames();
         c.info_port = 16'($urandom);
         c.sensor_addr_check = 1'($urandom);
         c.sensor_addr = $urandom;
         c.host_addr_check = 1'($urandom);
         c.host_addr = $urandom;
         case (ph)
            1: begin
               c.info_port = 16'hFFFF;
               c.sensor_addr_check = 1'b1;
               c.sensor_addr = 32'hFFFF_FFFF;
               c.host_addr_check = 1'b1;
               c.host_addr = 32'h0;
            end
            2: begin
               c.sensor_addr_check = 1'b1;
               c.host_addr_check = 1'b1;
            end
            3: begin
               c.sensor_addr_check = 1'b0;
               c.host_addr_check = 1'b0;
            end
            4: begin
               c.info_port = 16'h0;
               c.sensor_addr_check = 1'b1;
               c.sensor_addr = 32'h0;
               c.host_addr_check = 1'b1;
               c.host_addr = 32'hFFFF_FFFF;
            end
            default: ;
         endcase
         program_filters(c);
         bytes = 0;
         while (bytes < 30) begin
            draw_frame(h, caplen);
            assemble_frame(h, caplen);
            send_frame(1'b0, '0);
            bytes += caplen;
         end
      end

      drain_frames();
      if (mismatch_count == 0 && verdict_q.size() == 0)
         $display("[udp_frame_header_filter] OK");
      else
         $display("[udp_frame_header_filter] ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run under the longest receiver stalls
   initial begin
      #1_000_000;
      $display("[udp_frame_header_filter] ERROR");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/ufhf_pkg.sv
hw/rtl/ufhf_front.sv
hw/rtl/ufhf_queue.sv
hw/rtl/ufhf_back.sv
hw/rtl/udp_frame_header_filter.sv
bench/udp_frame_header_filter_tb.sv
